// ===== sv/echo_ranging_median_filter_macros.svh =====
// Assertion macros for the echo ranging median filter.
// ERM_ASSERT checks outside reset; ERM_ASSERT_RST checks on every edge.
`ifndef ECHO_RANGING_MEDIAN_FILTER_MACROS_SVH
`define ECHO_RANGING_MEDIAN_FILTER_MACROS_SVH

`ifndef SYNTH

`define ERM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("echo ranging median filter assertion failed");

`define ERM_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("echo ranging median filter reset assertion failed");

`else

`define ERM_ASSERT(label, prop)

`define ERM_ASSERT_RST(label, prop)

`endif

`endif

// ===== sv/erm_pkg.sv =====
package erm_pkg;

  // Field widths
  localparam int CM_W    = 11;
  localparam int STAMP_W = 16;
  localparam int CH_W    = 2;

  // Channel count and filter window
  localparam int SENSORS = 3;
  localparam int WINDOW  = 3;
  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int RANK_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int MID     = WINDOW / 2;

  // Constants
  localparam logic [SENSORS-1:0] FULL_MASK = 3'h7;
  localparam logic [CM_W-1:0]    START_CM  = 11'd400;
  localparam int CM_DIVISOR  = 58;
  localparam int RECIP_SHIFT = 22;
  localparam int CM_RECIP    = ((1 << RECIP_SHIFT) + CM_DIVISOR - 1) / CM_DIVISOR;
  localparam int RECIP_W     = 17;
  localparam int PROD_W      = STAMP_W + RECIP_W;

  // Command codes
  localparam logic CMD_ARM     = 1'b0;
  localparam logic CMD_CAPTURE = 1'b1;

  // Per-channel capture phase
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RISE = 2'd1,
    PH_FALL = 2'd2
  } phase_t;

  typedef logic [WINDOW-1:0][CM_W-1:0] window_t;

  typedef struct packed {
    logic               cmd;
    logic [CH_W-1:0]    channel;
    logic [STAMP_W-1:0] edge_stamp;
  } erm_in_t;

  typedef struct packed {
    logic [CM_W-1:0] left_filtered;
    logic [CM_W-1:0] right_filtered;
    logic [CM_W-1:0] center_filtered;
    logic [CM_W-1:0] left_raw;
    logic [CM_W-1:0] right_raw;
    logic [CM_W-1:0] center_raw;
  } erm_out_t;

endpackage

// ===== sv/echo_ranging_median_filter.sv =====
// Channel | Handshake              | Payload
// input   | req_valid / req_stall  | req : erm_in_t  (cmd, channel, edge_stamp)
// result  | rsp_valid / rsp_stall  | rsp : erm_out_t (three medians, three raw)
//
// One item per cycle unless req_stall holds the input register; a result is
// registered as its frame-closing item leaves the input register. An item
// that closes a frame waits there only while the result register is full and
// stalled; all other items pass regardless. Reset clears phases, stamps,
// slots and mask, and loads 400 into the raw distances and every window entry.
module echo_ranging_median_filter (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  erm_pkg::erm_in_t  req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output erm_pkg::erm_out_t rsp
);
  import erm_pkg::*;
  `include "echo_ranging_median_filter_macros.svh"

  // Input register
  logic    s1_valid;
  erm_in_t s1;

  // Channel state
  phase_t             phase      [SENSORS];
  logic [STAMP_W-1:0] rise_stamp [SENSORS];
  logic [CM_W-1:0]    raw        [SENSORS];
  logic [SLOT_W-1:0]  slot       [SENSORS];
  logic [CM_W-1:0]    win        [SENSORS][WINDOW];
  logic [SENSORS-1:0] done_mask;

  // Per-item logic
  logic               ch_ok;
  phase_t             ch_phase;
  logic [STAMP_W-1:0] pulse_width;
  logic [CM_W-1:0]    cm_dist;
  logic               completes;
  logic [SENSORS-1:0] done_mask_next;
  logic               emits;
  logic               s1_go;
  logic               fire;
  logic [CM_W-1:0]    raw_next [SENSORS];
  window_t            win_next [SENSORS];
  logic [CM_W-1:0]    med      [SENSORS];
  logic [SLOT_W-1:0]  slot_next;

  assign ch_ok       = (s1.channel < CH_W'(SENSORS));
  assign ch_phase    = ch_ok ? phase[s1.channel] : PH_IDLE;
  assign pulse_width = s1.edge_stamp - (ch_ok ? rise_stamp[s1.channel] : '0);

  erm_cm_div u_div (
    .pulse_width (pulse_width),
    .cm          (cm_dist)
  );

  assign completes      = s1_valid && ch_ok && (s1.cmd == CMD_CAPTURE) &&
                          (ch_phase == PH_FALL);
  assign done_mask_next = done_mask | (SENSORS'(1) << s1.channel);
  assign emits          = completes && (done_mask_next == FULL_MASK);

  // Hold a frame-closing item only while the result register cannot take it
  assign s1_go     = !emits || !rsp_valid || !rsp_stall;
  assign fire      = s1_valid && s1_go;
  assign req_stall = s1_valid && !s1_go;

  // Build the pushed windows with the new distance in place
  always_comb begin
    for (int s = 0; s < SENSORS; s++) begin
      raw_next[s] = (s1.channel == CH_W'(s)) ? cm_dist : raw[s];
      for (int k = 0; k < WINDOW; k++) begin
        win_next[s][k] = (slot[s] == SLOT_W'(k)) ? raw_next[s] : win[s][k];
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < SENSORS; g++) begin : g_med
      erm_median u_med (
        .win (win_next[g]),
        .med (med[g])
      );
    end
  endgenerate

  assign slot_next = (slot[0] == SLOT_W'(WINDOW - 1)) ? '0 : slot[0] + SLOT_W'(1);

  // Load the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall) begin
      s1 <= req;
    end
  end

  // Advance channel state and windows
  always_ff @(posedge clk) begin
    if (rst) begin
      done_mask <= '0;
      for (int s = 0; s < SENSORS; s++) begin
        phase[s]      <= PH_IDLE;
        rise_stamp[s] <= '0;
        raw[s]        <= START_CM;
        slot[s]       <= '0;
        for (int k = 0; k < WINDOW; k++) begin
          win[s][k] <= START_CM;
        end
      end
    end else if (fire && ch_ok) begin
      if (s1.cmd == CMD_ARM) begin
        phase[s1.channel] <= PH_RISE;
      end else begin
        case (ch_phase)
          PH_RISE: begin
            rise_stamp[s1.channel] <= s1.edge_stamp;
            phase[s1.channel]      <= PH_FALL;
          end
          PH_FALL: begin
            raw[s1.channel]   <= cm_dist;
            phase[s1.channel] <= PH_IDLE;
            if (emits) begin
              done_mask <= '0;
              for (int s = 0; s < SENSORS; s++) begin
                win[s][slot[s]] <= raw_next[s];
                slot[s]         <= slot_next;
              end
            end else begin
              done_mask <= done_mask_next;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result register: drop on transfer, load on a closed frame
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire && emits) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emits) begin
      rsp.left_filtered   <= med[0];
      rsp.right_filtered  <= med[1];
      rsp.center_filtered <= med[2];
      rsp.left_raw        <= raw_next[0];
      rsp.right_raw       <= raw_next[1];
      rsp.center_raw      <= raw_next[2];
    end
  end

  `ERM_ASSERT(a_mask_never_full, done_mask != FULL_MASK)
  `ERM_ASSERT(a_slots_in_step, (slot[0] == slot[1]) && (slot[1] == slot[2]))
  `ERM_ASSERT(a_load_needs_room, (fire && emits) |-> (!rsp_valid || !rsp_stall))
  `ERM_ASSERT(a_bad_channel_no_change, (s1_valid && !ch_ok) |=> $stable(done_mask))
  `ERM_ASSERT_RST(a_reset_clears, rst |=> (!rsp_valid && (done_mask == '0)))

endmodule

// ===== sv/erm_cm_div.sv =====
module erm_cm_div (
  input  logic [erm_pkg::STAMP_W-1:0] pulse_width,
  output logic [erm_pkg::CM_W-1:0]    cm
);
  import erm_pkg::*;

  logic [PROD_W-1:0] prod;

  // Divide by 58 through a rounded-up reciprocal; exact for every 16-bit width
  assign prod = PROD_W'(pulse_width) * PROD_W'(CM_RECIP);
  assign cm   = prod[RECIP_SHIFT +: CM_W];

endmodule

// ===== sv/erm_median.sv =====
module erm_median (
  input  erm_pkg::window_t          win,
  output logic [erm_pkg::CM_W-1:0]  med
);
  import erm_pkg::*;

  logic [RANK_W-1:0] rank [WINDOW];

  // Rank each entry; ties broken by position so ranks are unique
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < WINDOW; j++) begin
        if ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i))) begin
          rank[i] = rank[i] + RANK_W'(1);
        end
      end
    end
  end

  // Pick the entry that sits in the middle of the sorted order
  always_comb begin
    med = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (rank[i] == RANK_W'(MID)) begin
        med = win[i];
      end
    end
  end

endmodule

// ===== dv/testbench.sv =====
module testbench;
  import erm_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam logic [CH_W-1:0] CH_LEFT   = 2'd0;
  localparam logic [CH_W-1:0] CH_RIGHT  = 2'd1;
  localparam logic [CH_W-1:0] CH_CENTER = 2'd2;
  localparam logic [CH_W-1:0] CH_NONE   = 2'd3;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  erm_in_t  req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  erm_out_t rsp;

  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int stall_run = 0;
  bit calm = 1'b0;

  // Ranging state tracked alongside the block
  phase_t          ch_phase [SENSORS];
  logic [STAMP_W-1:0] rise_at [SENSORS];
  logic [CM_W-1:0] last_cm [SENSORS];
  logic [CM_W-1:0] ring [SENSORS][WINDOW];
  int              ring_slot [SENSORS];
  logic [SENSORS-1:0] frame_bits;
  erm_out_t        pending_frames [$];

  echo_ranging_median_filter i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #2 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results outstanding", $time,
               pending_frames.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Hold rsp_stall for random runs: mostly short, a few long
  always @(posedge clk) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if (calm) begin
      rsp_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          rsp_stall <= 1'b0;
          stall_run <= $urandom_range(0, 4);
        end
        9: begin
          rsp_stall <= 1'b1;
          stall_run <= $urandom_range(10, 40);
        end
        default: begin
          rsp_stall <= 1'b1;
          stall_run <= $urandom_range(0, 2);
        end
      endcase
    end
  end

  // Compare each result transfer with the oldest expected frame
  always @(negedge clk) begin
    erm_out_t want;
    logic [6*CM_W-1:0] want_bits;
    logic [6*CM_W-1:0] got_bits;
    string field_name [6];
    field_name = '{"center_raw", "right_raw", "left_raw",
                   "center_filtered", "right_filtered", "left_filtered"};
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected result %h", $time, rsp);
        errors++;
      end else begin
        want = pending_frames.pop_front();
        want_bits = want;
        got_bits = rsp;
        for (int f = 0; f < 6; f++) begin
          if (got_bits[f*CM_W +: CM_W] !== want_bits[f*CM_W +: CM_W]) begin
            $display("%0t: %s expected %0d actual %0d", $time, field_name[f],
                     want_bits[f*CM_W +: CM_W], got_bits[f*CM_W +: CM_W]);
            errors++;
          end
        end
      end
    end
  end

  function automatic logic [CM_W-1:0] ring_median(int s);
    logic [CM_W-1:0] v [WINDOW];
    logic [CM_W-1:0] key;
    int b;
    for (int a = 0; a < WINDOW; a++) v[a] = ring[s][a];
    for (int a = 1; a < WINDOW; a++) begin
      key = v[a];
      b = a;
      while (b > 0 && v[b-1] > key) begin
        v[b] = v[b-1];
        b--;
      end
      v[b] = key;
    end
    return v[MID];
  endfunction

  function automatic void clear_ranging();
    for (int s = 0; s < SENSORS; s++) begin
      ch_phase[s] = PH_IDLE;
      rise_at[s] = '0;
      last_cm[s] = START_CM;
      ring_slot[s] = 0;
      for (int k = 0; k < WINDOW; k++) ring[s][k] = START_CM;
    end
    frame_bits = '0;
  endfunction

  // Advance the ranging state by one transfer; queue a frame when all channels are in
  function automatic void track_transfer(erm_in_t it);
    int ch;
    logic [STAMP_W-1:0] width;
    erm_out_t fr;
    ch = int'(it.channel);
    if (ch >= SENSORS) return;
    if (it.cmd == CMD_ARM) begin
      ch_phase[ch] = PH_RISE;
      return;
    end
    if (ch_phase[ch] == PH_RISE) begin
      rise_at[ch] = it.edge_stamp;
      ch_phase[ch] = PH_FALL;
      return;
    end
    if (ch_phase[ch] != PH_FALL) return;
    width = it.edge_stamp - rise_at[ch];
    last_cm[ch] = CM_W'(width / CM_DIVISOR);
    ch_phase[ch] = PH_IDLE;
    frame_bits[ch] = 1'b1;
    if (frame_bits != FULL_MASK) return;
    for (int s = 0; s < SENSORS; s++) begin
      ring[s][ring_slot[s]] = last_cm[s];
      ring_slot[s] = (ring_slot[s] + 1) % WINDOW;
    end
    fr.left_filtered   = ring_median(0);
    fr.right_filtered  = ring_median(1);
    fr.center_filtered = ring_median(2);
    fr.left_raw        = last_cm[0];
    fr.right_raw       = last_cm[1];
    fr.center_raw      = last_cm[2];
    pending_frames.push_back(fr);
    frame_bits = '0;
  endfunction

  // Drop valid for a random gap before the next transfer
  task automatic sender_gap();
    int n;
    n = 0;
    if (!calm) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: n = 0;
        9:                n = $urandom_range(5, 30);
        default:          n = $urandom_range(1, 3);
      endcase
    end
    if (n > 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Send one request and wait for its transfer
  task automatic drive_request(logic cmd, logic [CH_W-1:0] ch, logic [STAMP_W-1:0] stamp);
    erm_in_t it;
    bit taken;
    it.cmd = cmd;
    it.channel = ch;
    it.edge_stamp = stamp;
    sender_gap();
    req <= it;
    req_valid <= 1'b1;
    do begin
      @(negedge clk);
      taken = !req_stall;
      @(posedge clk);
    end while (!taken);
    track_transfer(it);
    items_sent++;
  endtask

  function automatic logic [STAMP_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 16'd0;
          1:       return 16'd57;
          2:       return 16'd58;
          3:       return 16'hFFFF;
          default: return 16'hFFC6;
        endcase
      end
      1, 2:    return STAMP_W'($urandom_range(0, 16'hFFFF));
      default: return STAMP_W'($urandom_range(0, 23200));
    endcase
  endfunction

  // Arm, rise, fall on every channel with channels interleaved at random; broken adds random noise items
  task automatic send_frame(bit broken);
    int step [SENSORS];
    logic [STAMP_W-1:0] rise [SENSORS];
    int c;
    for (int s = 0; s < SENSORS; s++) step[s] = 0;
    while (step[0] < 3 || step[1] < 3 || step[2] < 3) begin
      c = $urandom_range(0, SENSORS - 1);
      if (step[c] == 3) continue;
      if (broken && $urandom_range(0, 5) == 0)
        drive_request(1'($urandom_range(0, 1)), CH_W'($urandom_range(0, 3)),
                      STAMP_W'($urandom));
      case (step[c])
        0: drive_request(CMD_ARM, CH_W'(c), STAMP_W'($urandom));
        1: begin
          rise[c] = STAMP_W'($urandom);
          drive_request(CMD_CAPTURE, CH_W'(c), rise[c]);
        end
        default: drive_request(CMD_CAPTURE, CH_W'(c), rise[c] + pick_width());
      endcase
      step[c]++;
    end
  endtask

  task automatic test_directed();
    // ignored: edge on idle channel, channel three
    drive_request(CMD_CAPTURE, CH_LEFT, 16'h1234);
    drive_request(CMD_ARM, CH_NONE, 16'hFFFF);
    drive_request(CMD_CAPTURE, CH_NONE, 16'hFFFF);
    // largest width, wrapped width, zero width
    drive_request(CMD_ARM, CH_LEFT, 16'h0000);
    drive_request(CMD_CAPTURE, CH_LEFT, 16'h0000);
    drive_request(CMD_CAPTURE, CH_LEFT, 16'hFFFF);
    drive_request(CMD_ARM, CH_RIGHT, 16'h0000);
    drive_request(CMD_CAPTURE, CH_RIGHT, 16'd65000);
    drive_request(CMD_CAPTURE, CH_RIGHT, 16'd100);
    drive_request(CMD_ARM, CH_CENTER, 16'h0000);
    drive_request(CMD_CAPTURE, CH_CENTER, 16'd5);
    drive_request(CMD_CAPTURE, CH_CENTER, 16'd5);
    // re-arm during capture discards the first rise
    drive_request(CMD_ARM, CH_LEFT, 16'h0000);
    drive_request(CMD_CAPTURE, CH_LEFT, 16'd1000);
    drive_request(CMD_ARM, CH_LEFT, 16'h0000);
    drive_request(CMD_CAPTURE, CH_LEFT, 16'd2000);
    drive_request(CMD_CAPTURE, CH_LEFT, 16'd2000 + 16'd17400);
    // right completes twice before the frame closes
    drive_request(CMD_ARM, CH_RIGHT, 16'h0000);
    drive_request(CMD_CAPTURE, CH_RIGHT, 16'd300);
    drive_request(CMD_CAPTURE, CH_RIGHT, 16'd357);
    drive_request(CMD_ARM, CH_RIGHT, 16'h0000);
    drive_request(CMD_CAPTURE, CH_RIGHT, 16'd300);
    drive_request(CMD_CAPTURE, CH_RIGHT, 16'd358);
    drive_request(CMD_ARM, CH_CENTER, 16'h0000);
    drive_request(CMD_CAPTURE, CH_CENTER, 16'hFFFF);
    drive_request(CMD_CAPTURE, CH_CENTER, 16'd6000);
  endtask

  task automatic test_random_frames();
    while (items_sent < 1150) send_frame($urandom_range(0, 4) == 0);
  endtask

  task automatic test_noise();
    repeat (250)
      drive_request(1'($urandom_range(0, 1)), CH_W'($urandom_range(0, 3)),
                    STAMP_W'($urandom));
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    repeat (12) send_frame(1'b0);
    calm = 1'b0;
  endtask

  initial begin
    clear_ranging();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_frames();
    test_noise();
    test_back_to_back();
    test_random_frames();
    req_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
